### design/ffba_pkg.sv
`default_nettype none
package ffba_pkg;
	localparam int MAX_OPEN_D = 16;
	localparam int MAX_BLOCKS_D = 256;
	localparam int MAX_BIG_D = 256;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALIGN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIG = 2'd3;
	localparam logic [1:0] PL_OPEN = 2'd0;
	localparam logic [1:0] PL_FRESH = 2'd1;
	localparam logic [1:0] PL_BIG = 2'd2;
	localparam logic [1:0] FC_NONE = 2'd0;
	localparam logic [1:0] FC_SIZE = 2'd1;
	localparam logic [1:0] FC_EXHAUST = 2'd2;
	localparam logic [1:0] FC_BLOCK = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_SIZE, ST_CLASS, ST_RD, ST_CHK, ST_SHRD, ST_SHWR, ST_OUT
	} state_t;

	typedef struct packed {
		logic        we;
		logic [7:0]  waddr;
		logic [7:0]  raddr;
		logic [24:0] wdata;
	} mem_req_t;
endpackage
`default_nettype wire

### design/first_fit_block_arena_allocator.sv
// big, failed, empty-list requests: mul, size, class, read, check states, then the result beat
// small request: a read and check per open entry scanned; when a block fills, a shift per entry
// one request at a time, the next one accepted once the result beat is taken
// the serial first-fit scan through the open list memory sets the rate
// reset: arst_n clears counters and open count and sets the config registers to their defaults
// the open list memory holds no reset value; only entries below the open count are used
`default_nettype none
module first_fit_block_arena_allocator #(
	parameter int MAX_OPEN = ffba_pkg::MAX_OPEN_D,
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_D,
	parameter int MAX_BIG = ffba_pkg::MAX_BIG_D
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ffba_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [31:0]                   element_size,
	input  wire logic [31:0]                   element_count,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               granted,
	output logic [1:0]                         placement,
	output logic [7:0]                         slot_id,
	output logic [15:0]                        byte_offset,
	output logic [31:0]                        granted_size,
	output logic [1:0]                         fail_code
);
	localparam int OCW = $clog2(MAX_OPEN + 1);
	localparam int BIDW = $clog2(MAX_BLOCKS + 1);
	localparam int BGW = $clog2(MAX_BIG + 1);

	ffba_pkg::state_t state_q, state_d;
	logic [16:0] bsize_q, margin_q, bigth_q;
	logic [12:0] align_q;
	logic [OCW-1:0] open_cnt_q, idx_q;
	logic [BIDW-1:0] next_id_q;
	logic [8:0] full_cnt_q;
	logic [BGW-1:0] big_cnt_q;
	logic [31:0] succ_q;
	logic [15:0] a_lo_q, a_hi_q, b_lo_q, b_hi_q;
	logic [31:0] p0_q, p1_q, p2_q, p3_q;
	logic [32:0] size_q;
	logic [12:0] palign_q;
	logic [16:0] beff_q;
	logic [24:0] rdata;
	ffba_pkg::mem_req_t req;

	ffba_list_mem #(.DEPTH(MAX_OPEN)) u_mem (.clk(clk), .req(req), .rdata(rdata));

	logic [12:0] palign;
	always_comb begin
		palign = 13'd1;
		for (int k = 0; k < 13; k++)
			if (align_q[k]) palign = 13'd1 << k;
	end

	logic [63:0] prod;
	logic [31:0] mask;
	logic [32:0] szc;
	assign prod = {32'd0, p0_q} + {16'd0, p1_q, 16'd0} + {16'd0, p2_q, 16'd0} + {p3_q, 32'd0};
	assign mask = ~({19'd0, palign_q} - 32'd1);
	assign szc = {1'b0, prod[31:0] & mask} + {20'd0, palign_q};

	logic [16:0] left, newleft, rem;
	logic [7:0] rid;
	logic fits;
	assign left = rdata[16:0];
	assign rid = rdata[24:17];
	assign fits = size_q[31:0] <= {15'd0, left};
	assign newleft = left - size_q[16:0];
	assign rem = (beff_q - size_q[16:0]) & mask[16:0];

	logic [7:0] slot_q;
	logic [15:0] off_q;
	logic [1:0] pl_q, fc_q;
	logic gr_q, ov_q;

	logic hit, more, fresh_ok, fresh_list;
	assign hit = !ov_q && (idx_q < open_cnt_q) && fits;
	assign more = !ov_q && !hit && (idx_q + 1'b1 < open_cnt_q);
	assign fresh_ok = !ov_q && !hit && !more
		&& ({1'b0, next_id_q} < (BIDW+1)'(MAX_BLOCKS))
		&& (rem < margin_q || {1'b0, open_cnt_q} < (OCW+1)'(MAX_OPEN));
	assign fresh_list = fresh_ok && rem >= margin_q;

	always_comb begin
		state_d = state_q;
		req = '0;
		req.raddr = 8'(idx_q);
		case (state_q)
			ffba_pkg::ST_IDLE: if (in_valid) state_d = ffba_pkg::ST_MUL;
			ffba_pkg::ST_MUL: state_d = ffba_pkg::ST_SIZE;
			ffba_pkg::ST_SIZE: state_d = ffba_pkg::ST_CLASS;
			ffba_pkg::ST_CLASS: state_d = ffba_pkg::ST_RD;
			ffba_pkg::ST_RD: state_d = ffba_pkg::ST_CHK;
			ffba_pkg::ST_CHK: begin
				state_d = ffba_pkg::ST_OUT;
				if (hit) begin
					req.we = 1'b1;
					req.waddr = 8'(idx_q);
					req.wdata = {rid, newleft};
					if (newleft < margin_q) begin
						req.raddr = 8'(idx_q + 1'b1);
						state_d = ffba_pkg::ST_SHRD;
					end
				end else if (more) begin
					req.raddr = 8'(idx_q + 1'b1);
					state_d = ffba_pkg::ST_RD;
				end else if (fresh_list) begin
					req.we = 1'b1;
					req.waddr = 8'(open_cnt_q);
					req.wdata = {8'(next_id_q), rem};
				end
			end
			ffba_pkg::ST_SHRD: begin
				req.raddr = 8'(idx_q + 1'b1);
				state_d = ffba_pkg::ST_SHWR;
			end
			ffba_pkg::ST_SHWR: begin
				if (idx_q < open_cnt_q) begin
					req.we = 1'b1;
					req.waddr = 8'(idx_q);
					req.wdata = rdata;
					req.raddr = 8'(idx_q + 2'd2);
					state_d = ffba_pkg::ST_SHRD;
				end else state_d = ffba_pkg::ST_OUT;
			end
			ffba_pkg::ST_OUT: if (!out_stall) state_d = ffba_pkg::ST_IDLE;
			default: state_d = ffba_pkg::ST_IDLE;
		endcase
	end

	assign in_stall = state_q != ffba_pkg::ST_IDLE;
	assign out_valid = state_q == ffba_pkg::ST_OUT;
	assign granted = gr_q;
	assign placement = pl_q;
	assign slot_id = slot_q;
	assign byte_offset = off_q;
	assign granted_size = gr_q ? size_q[31:0] : 32'd0;
	assign fail_code = fc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::ST_IDLE;
			bsize_q <= 17'd4096;
			align_q <= 13'd16;
			margin_q <= 17'd64;
			bigth_q <= 17'd2048;
			open_cnt_q <= '0;
			next_id_q <= '0;
			full_cnt_q <= '0;
			big_cnt_q <= '0;
			succ_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					ffba_pkg::REG_BLOCK_SIZE: bsize_q <= cfg_data;
					ffba_pkg::REG_ALIGN: align_q <= cfg_data[12:0];
					ffba_pkg::REG_MARGIN: margin_q <= cfg_data;
					ffba_pkg::REG_BIG: bigth_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ffba_pkg::ST_CLASS && !ov_q && size_q[31:0] >= {15'd0, bigth_q}
					&& {1'b0, big_cnt_q} < (BGW+1)'(MAX_BIG))
				big_cnt_q <= big_cnt_q + 1'b1;
			if (state_q == ffba_pkg::ST_CHK) begin
				if (hit && newleft < margin_q) begin
					open_cnt_q <= open_cnt_q - 1'b1;
					full_cnt_q <= full_cnt_q + 1'b1;
				end else if (fresh_ok) begin
					if (fresh_list)
						open_cnt_q <= open_cnt_q + 1'b1;
					else
						full_cnt_q <= full_cnt_q + 1'b1;
					next_id_q <= next_id_q + 1'b1;
				end
			end
			if (state_q == ffba_pkg::ST_OUT && !out_stall && gr_q && succ_q != 32'hFFFF_FFFF)
				succ_q <= succ_q + 1'b1;
		end
	end

	// datapath: multiply in 16x16 pieces, then classify and scan
	always_ff @(posedge clk) begin
		case (state_q)
			ffba_pkg::ST_IDLE: begin
				a_lo_q <= element_size[15:0];
				a_hi_q <= element_size[31:16];
				b_lo_q <= element_count[15:0];
				b_hi_q <= element_count[31:16];
			end
			ffba_pkg::ST_MUL: begin
				p0_q <= a_lo_q * b_lo_q;
				p1_q <= a_hi_q * b_lo_q;
				p2_q <= a_lo_q * b_hi_q;
				p3_q <= a_hi_q * b_hi_q;
				palign_q <= palign;
				beff_q <= (bsize_q > 17'd65536) ? 17'd65536 : bsize_q;
			end
			ffba_pkg::ST_SIZE: begin
				size_q <= szc;
				ov_q <= (prod[63:32] != 32'd0) || szc[32] || (szc == 33'd0);
			end
			ffba_pkg::ST_CLASS: begin
				idx_q <= '0;
				gr_q <= 1'b0; pl_q <= ffba_pkg::PL_OPEN; slot_q <= '0; off_q <= '0;
				fc_q <= ffba_pkg::FC_SIZE;
				if (!ov_q) begin
					if (size_q[31:0] >= {15'd0, bigth_q}) begin
						if ({1'b0, big_cnt_q} < (BGW+1)'(MAX_BIG)) begin
							gr_q <= 1'b1; pl_q <= ffba_pkg::PL_BIG;
							slot_q <= 8'(big_cnt_q); fc_q <= ffba_pkg::FC_NONE;
						end else fc_q <= ffba_pkg::FC_EXHAUST;
						ov_q <= 1'b1;
					end else if (size_q[31:0] > {15'd0, beff_q}) begin
						fc_q <= ffba_pkg::FC_BLOCK;
						ov_q <= 1'b1;
					end
				end
			end
			ffba_pkg::ST_CHK: begin
				if (hit) begin
					gr_q <= 1'b1; pl_q <= ffba_pkg::PL_OPEN; slot_q <= rid;
					off_q <= 16'(beff_q - left); fc_q <= ffba_pkg::FC_NONE;
				end else if (fresh_ok) begin
					gr_q <= 1'b1; pl_q <= ffba_pkg::PL_FRESH;
					slot_q <= 8'(next_id_q); fc_q <= ffba_pkg::FC_NONE;
				end else if (more) begin
					idx_q <= idx_q + 1'b1;
				end else if (!ov_q) begin
					fc_q <= ffba_pkg::FC_EXHAUST;
				end
			end
			ffba_pkg::ST_SHWR: idx_q <= idx_q + 1'b1;
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, open_cnt_q} <= (OCW+1)'(MAX_OPEN)) else $error("open count out of range");
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> slot_id == '0 && granted_size == '0 || fail_code != '0)
		else $error("failed result carries data");
	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> fail_code == ffba_pkg::FC_NONE) else $error("grant with code");
`endif
endmodule
`default_nettype wire

### design/ffba_list_mem.sv
`default_nettype none
module ffba_list_mem #(
	parameter int DEPTH = ffba_pkg::MAX_OPEN_D,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic               clk,
	input  wire ffba_pkg::mem_req_t req,
	output logic [24:0]             rdata
);
	logic [24:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr[AW-1:0]] <= req.wdata;
		rdata <= mem[req.raddr[AW-1:0]];
	end
endmodule
`default_nettype wire
